// ===== sv/gsa_pkg.sv =====
package gsa_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int GEN_W = 16;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_FREE    = 2'd1;
  localparam logic [1:0] STAT_BAD_HANDLE = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] generation;
  } gsa_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic [CNT_W-1:0] freed_count;
  } gsa_out_t;

  typedef struct packed {
    logic             refill;
    logic [CNT_W-1:0] refill_count;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_slot;
  } gsa_stk_ctrl_t;

endpackage

// ===== sv/generational_slot_allocator.sv =====
// generational slot allocator
// hands out handles (slot index + generation) from a lifo free stack.
// input channel in_valid/in_ready/in_data carries a command: allocate, destroy,
// check or flush. every command gives exactly one transfer on out_valid/
// out_ready/out_data with a status, the allocated handle or the freed count.
// cfg_valid/cfg_ready/cfg_data writes the capacity (saturates at the slot count),
// refills the free stack with 0..capacity-1, drops pending frees and clears all
// occupied bits; generations are kept. cfg_ready is always high.
// an allocate with no free slot is answered from the idle state; for the rest, the
// time from input transfer to result is set by the single port of each slot memory
// and, for a flush, by the one-entry-per-cycle walk of the pending list.
// one command is in flight at a time; in_ready is high only when idle.
// after reset, and after each capacity write, a clearing pass over all 1024 slots
// of the slot memories runs with in_ready low (reset also zeroes all generations).
// a stalled receiver holds the result in the output register; the next command
// may be taken in the same cycle the held result transfers.
module generational_slot_allocator import gsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gsa_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gsa_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ALLOC1 = 3'd2;
  localparam logic [2:0] ST_ALLOC2 = 3'd3;
  localparam logic [2:0] ST_HANDLE = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] pcount_r, pcount_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt;
  logic             clr_gen_r, clr_gen_nxt;
  gsa_in_t          req_r, req_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] fl_i_r, fl_i_nxt;
  logic             fl_v_r, fl_v_nxt;
  logic [CNT_W-1:0] freed_r, freed_nxt;
  logic             out_valid_r, out_valid_nxt;
  gsa_out_t         out_data_r, out_data_nxt;

  // slot memories
  logic [GEN_W-1:0] gen_mem  [SLOTS];
  logic             occ_mem  [SLOTS];
  logic [IDX_W-1:0] pend_mem [SLOTS];
  logic [GEN_W-1:0] gen_q;
  logic             occ_q;
  logic [IDX_W-1:0] pend_q;

  logic             gen_we, occ_we, pend_we;
  logic [IDX_W-1:0] gen_waddr, occ_waddr, pend_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic             occ_wdata;
  logic [IDX_W-1:0] pend_wdata;
  logic [IDX_W-1:0] slot_raddr, pend_raddr;

  gsa_stk_ctrl_t    stk_ctrl;
  logic [CNT_W-1:0] stk_count;
  logic [IDX_W-1:0] stk_top;

  logic             in_acc;
  logic             res_valid;
  gsa_out_t         res;
  logic             handle_ok;

  gsa_free_stack u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (stk_ctrl),
    .count    (stk_count),
    .top_slot (stk_top)
  );

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // handle is good when in range, generation matches and the slot is live
  assign handle_ok = ({1'b0, req_r.slot_index} < cap_r) && (gen_q == req_r.generation) && occ_q;

  always_comb begin
    state_nxt   = state_r;
    cap_nxt     = cap_r;
    pcount_nxt  = pcount_r;
    sweep_nxt   = sweep_r;
    clr_gen_nxt = clr_gen_r;
    req_nxt     = req_r;
    slot_nxt    = slot_r;
    fl_i_nxt    = fl_i_r;
    fl_v_nxt    = fl_v_r;
    freed_nxt   = freed_r;

    gen_we      = 1'b0;
    gen_waddr   = req_r.slot_index;
    gen_wdata   = gen_q + GEN_W'(1);
    occ_we      = 1'b0;
    occ_waddr   = req_r.slot_index;
    occ_wdata   = 1'b0;
    pend_we     = 1'b0;
    pend_waddr  = pcount_r[IDX_W-1:0];
    pend_wdata  = req_r.slot_index;
    slot_raddr  = req_r.slot_index;
    pend_raddr  = fl_i_r[IDX_W-1:0];

    stk_ctrl              = '0;
    stk_ctrl.refill_count = cap_r;
    stk_ctrl.push_slot    = pend_q;

    res_valid = 1'b0;
    res       = '0;

    case (state_r)
      ST_SWEEP: begin
        // one slot per cycle: clear occupied, and generation after reset
        occ_we    = 1'b1;
        occ_waddr = sweep_r;
        occ_wdata = 1'b0;
        gen_we    = clr_gen_r;
        gen_waddr = sweep_r;
        gen_wdata = '0;
        sweep_nxt = sweep_r + IDX_W'(1);
        if (sweep_r == IDX_W'(SLOTS - 1)) begin
          state_nxt   = ST_IDLE;
          clr_gen_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        slot_raddr = in_data.slot_index;
        if (in_acc) begin
          req_nxt = in_data;
          case (in_data.cmd)
            CMD_ALLOC: begin
              if (stk_count == '0) begin
                res_valid  = 1'b1;
                res.status = STAT_NO_FREE;
              end else begin
                stk_ctrl.pop = 1'b1;
                state_nxt    = ST_ALLOC1;
              end
            end
            CMD_DESTROY, CMD_CHECK: begin
              state_nxt = ST_HANDLE;
            end
            CMD_FLUSH: begin
              fl_i_nxt  = '0;
              fl_v_nxt  = 1'b0;
              freed_nxt = '0;
              state_nxt = ST_FLUSH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ALLOC1: begin
        // popped slot is ready; fetch its generation
        slot_raddr = stk_top;
        slot_nxt   = stk_top;
        state_nxt  = ST_ALLOC2;
      end
      ST_ALLOC2: begin
        occ_we             = 1'b1;
        occ_waddr          = slot_r;
        occ_wdata          = 1'b1;
        res_valid          = 1'b1;
        res.status         = STAT_OK;
        res.out_index      = slot_r;
        res.out_generation = gen_q;
        state_nxt          = ST_IDLE;
      end
      ST_HANDLE: begin
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
        if (!handle_ok) begin
          res.status = STAT_BAD_HANDLE;
        end else begin
          res.status = STAT_OK;
          if (req_r.cmd == CMD_DESTROY) begin
            gen_we    = 1'b1;
            occ_we    = 1'b1;
            occ_wdata = 1'b0;
            if (pcount_r < SLOTS_CNT) begin
              pend_we    = 1'b1;
              pcount_nxt = pcount_r + CNT_W'(1);
            end
          end
        end
      end
      ST_FLUSH: begin
        // read side: one pending entry per cycle
        if (fl_i_r < pcount_r) begin
          fl_i_nxt = fl_i_r + CNT_W'(1);
          fl_v_nxt = 1'b1;
        end else begin
          fl_v_nxt = 1'b0;
        end
        // push side: entry read last cycle goes onto the free stack unless it is full
        if (fl_v_r && (stk_count < SLOTS_CNT)) begin
          stk_ctrl.push = 1'b1;
          freed_nxt     = freed_r + CNT_W'(1);
        end
        if ((fl_i_r == pcount_r) && !fl_v_r) begin
          res_valid       = 1'b1;
          res.status      = STAT_OK;
          res.freed_count = freed_r;
          pcount_nxt      = '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // capacity write: refill the stack, drop pending, clear occupied bits
    if (cfg_valid) begin
      cap_nxt               = (cfg_data > SLOTS_CNT) ? SLOTS_CNT : cfg_data;
      stk_ctrl.refill       = 1'b1;
      stk_ctrl.refill_count = cap_nxt;
      pcount_nxt            = '0;
      sweep_nxt             = '0;
      state_nxt             = ST_SWEEP;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cap_r       <= SLOTS_CNT;
      pcount_r    <= '0;
      sweep_r     <= '0;
      clr_gen_r   <= 1'b1;
      fl_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      pcount_r    <= pcount_nxt;
      sweep_r     <= sweep_nxt;
      clr_gen_r   <= clr_gen_nxt;
      fl_v_r      <= fl_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    fl_i_r     <= fl_i_nxt;
    freed_r    <= freed_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    gen_q <= gen_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_q <= occ_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_q <= pend_mem[pend_raddr];
  end

  // free slots never outnumber the capacity
  a_free_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (stk_count <= cap_r))
    else $error("free stack holds more slots than capacity");

  // an allocated slot is always inside the capacity
  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC2) |-> ({1'b0, slot_r} < cap_r))
    else $error("allocated slot outside capacity");

  // a destroy, check or flush transfer blocks the input until its result is formed
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.cmd != CMD_ALLOC)) |=> !in_ready)
    else $error("input taken while a command is in flight");

  // finishing a flush empties the pending list
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && (fl_i_r == pcount_r) && !fl_v_r && !cfg_valid)
      |=> (pcount_r == '0))
    else $error("pending list not empty after flush");

endmodule

// ===== sv/gsa_free_stack.sv =====
module gsa_free_stack import gsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  gsa_stk_ctrl_t    ctrl,
  output logic [CNT_W-1:0] count,
  output logic [IDX_W-1:0] top_slot
);

  logic [IDX_W-1:0] mem [SLOTS];
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  // lowest position written since the last refill; everything below still reads as its own index
  logic [CNT_W-1:0] low_r, low_nxt;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] pop_pos;

  assign count_dec = count_r - CNT_W'(1);
  assign pop_pos   = count_dec[IDX_W-1:0];

  always_comb begin
    count_nxt = count_r;
    low_nxt   = low_r;
    if (ctrl.refill) begin
      count_nxt = ctrl.refill_count;
      low_nxt   = SLOTS_CNT;
    end else if (ctrl.pop) begin
      count_nxt = count_dec;
    end else if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r < low_r) begin
        low_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SLOTS_CNT;
      low_r   <= SLOTS_CNT;
    end else begin
      count_r <= count_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.refill) begin
      mem[count_r[IDX_W-1:0]] <= ctrl.push_slot;
    end
    rd_q <= mem[pop_pos];
    if (ctrl.pop) begin
      pos_r <= pop_pos;
    end
  end

  assign count    = count_r;
  assign top_slot = ({1'b0, pos_r} < low_r) ? pos_r : rd_q;

endmodule

// ===== test/generational_slot_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_tb;
  import gsa_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // command channel
  logic in_valid = 1'b0;
  logic in_ready;
  gsa_in_t in_data = '0;

  // result channel
  logic out_valid;
  logic out_ready = 1'b0;
  gsa_out_t out_data;

  // capacity register write port
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // commands waiting for the driver, results waiting for the checker
  gsa_in_t cmd_queue[$];
  gsa_out_t expected_results[$];

  int fail_cnt = 0;
  int in_gap = 0;
  int out_stall = 0;
  // when set, neither side inserts bubbles
  bit calm = 1'b0;

  // shadow of the allocator state
  logic [IDX_W-1:0] free_stk [SLOTS];
  logic [GEN_W-1:0] slot_gen [SLOTS];
  bit slot_busy [SLOTS];
  logic [IDX_W-1:0] pend_list [SLOTS];
  int free_cnt;
  int pend_cnt;
  int cap_now;

  generational_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back-to-back, some short bubbles, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // capacity write: free stack holds 0..c-1 with the top slot on top,
  // nothing occupied, nothing pending, generations untouched
  function automatic void reload_free_stack(int c);
    int k;
    for (k = 0; k < SLOTS; k++) begin
      free_stk[k] = IDX_W'(k);
      slot_busy[k] = 1'b0;
    end
    cap_now = c;
    free_cnt = c;
    pend_cnt = 0;
  endfunction

  // result of one command, applied to the shadow state
  function automatic gsa_out_t predict_slot_result(gsa_in_t req);
    gsa_out_t res;
    logic [IDX_W-1:0] s;
    bit handle_ok;
    int k;
    res = '0;
    // a handle is live only if in range, current generation and occupied
    handle_ok = (int'(req.slot_index) < cap_now) && slot_busy[req.slot_index] &&
                (slot_gen[req.slot_index] == req.generation);
    case (req.cmd)
      CMD_ALLOC: begin
        if (free_cnt == 0) begin
          res.status = STAT_NO_FREE;
        end else begin
          free_cnt--;
          s = free_stk[free_cnt];
          slot_busy[s] = 1'b1;
          res.out_index = s;
          res.out_generation = slot_gen[s];
        end
      end
      CMD_DESTROY: begin
        if (!handle_ok) begin
          res.status = STAT_BAD_HANDLE;
        end else begin
          // generation bump wraps at the field width
          slot_gen[req.slot_index] = slot_gen[req.slot_index] + 1'b1;
          slot_busy[req.slot_index] = 1'b0;
          if (pend_cnt < SLOTS) begin
            pend_list[pend_cnt] = req.slot_index;
            pend_cnt++;
          end
        end
      end
      CMD_CHECK: begin
        if (!handle_ok) res.status = STAT_BAD_HANDLE;
      end
      default: begin
        // flush: pending slots go back on the stack in list order
        for (k = 0; k < pend_cnt; k++) begin
          if (free_cnt < SLOTS) begin
            free_stk[free_cnt] = pend_list[k];
            free_cnt++;
            res.freed_count = res.freed_count + 1'b1;
          end
        end
        pend_cnt = 0;
      end
    endcase
    return res;
  endfunction

  // driver: pulls commands from the queue, predicts at each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      // register write lands at this edge, ahead of any later command
      if (cfg_valid && cfg_ready)
        reload_free_stack((cfg_data > SLOTS_CNT) ? SLOTS : int'(cfg_data));
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), predict_slot_result(in_data));
      // channel is free unless a command is still waiting for in_ready
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (cmd_queue.size() != 0) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // monitor: random backpressure, compares each result transfer in order
  always @(posedge clk) begin
    gsa_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("out_index", 32'(want.out_index), 32'(out_data.out_index));
          check_field("out_generation", 32'(want.out_generation),
                      32'(out_data.out_generation));
          check_field("freed_count", 32'(want.freed_count), 32'(out_data.freed_count));
        end
      end
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  // queue one command, keeping at most two ahead of the driver so that
  // handles picked from the shadow state are mostly still current
  task automatic send(logic [1:0] c, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    gsa_in_t item;
    item.cmd = c;
    item.slot_index = idx;
    item.generation = gen;
    while (cmd_queue.size() >= 2) @(negedge clk);
    cmd_queue.insert(cmd_queue.size(), item);
  endtask

  // everything sent has been accepted and every result has come back
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // capacity write only while the block is idle
  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain();
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // some occupied slot below the current capacity, or -1
  function automatic int find_busy_slot();
    int start;
    int k;
    int j;
    if (cap_now == 0) return -1;
    start = $urandom_range(0, cap_now - 1);
    for (k = 0; k < cap_now; k++) begin
      j = (start + k) % cap_now;
      if (slot_busy[j]) return j;
    end
    return -1;
  endfunction

  // one random command: mostly alloc / destroy / check / flush on live
  // handles, the rest stale generations, out-of-range indexes and noise
  task automatic send_random();
    int r;
    int s;
    logic [1:0] c;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    r = $urandom_range(0, 99);
    c = CMD_ALLOC;
    idx = IDX_W'($urandom_range(0, SLOTS - 1));
    gen = GEN_W'($urandom_range(0, 65535));
    if (r < 35) begin
      c = CMD_ALLOC;
    end else if (r < 43) begin
      c = CMD_FLUSH;
    end else if (r < 83) begin
      s = find_busy_slot();
      if (s >= 0) begin
        c = (r < 70) ? CMD_DESTROY : CMD_CHECK;
        idx = IDX_W'(s);
        gen = slot_gen[s];
        // wrong generation on an occupied slot
        if (r >= 78) gen = gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
      end
    end else if (r < 90) begin
      c = $urandom_range(0, 1) ? CMD_DESTROY : CMD_CHECK;
      if (cap_now < SLOTS)
        idx = IDX_W'((cap_now + $urandom_range(0, 3) > SLOTS - 1) ?
                     SLOTS - 1 : cap_now + $urandom_range(0, 3));
    end else begin
      c = 2'($urandom_range(0, 3));
    end
    send(c, idx, gen);
  endtask

  initial begin
    int phase_cap [10];
    int p;
    int n;
    phase_cap = '{2047, 5, 1, 37, 0, 2, 1000, 3, 64, 1024};
    phase_cap[4] = $urandom_range(0, 2047);

    // shadow state after reset: all generations zero, full capacity
    for (n = 0; n < SLOTS; n++) slot_gen[n] = '0;
    reload_free_stack(SLOTS);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default capacity, empty flush, unoccupied check, allocate
    // with junk handle fields, good and bad handles, reuse after flush
    send(CMD_FLUSH, '0, '0);
    send(CMD_CHECK, '0, '0);
    send(CMD_ALLOC, '1, '1);
    send(CMD_ALLOC, '0, '0);
    send(CMD_CHECK, 10'd1023, 16'd0);
    send(CMD_CHECK, 10'd1023, 16'd1);
    send(CMD_DESTROY, 10'd1023, 16'hFFFF);
    send(CMD_DESTROY, 10'd1023, 16'd0);
    send(CMD_DESTROY, 10'd1023, 16'd1);
    send(CMD_FLUSH, '0, '0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_CHECK, 10'd1023, 16'd1);

    // zero capacity while slots are in use: nothing to hand out
    write_capacity('0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_DESTROY, '0, '0);
    send(CMD_CHECK, '0, '0);
    send(CMD_FLUSH, '0, '0);

    // single slot: exhaustion, index past capacity, generation reuse
    write_capacity(CNT_W'(1));
    send(CMD_ALLOC, '0, '0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_DESTROY, '0, '0);
    send(CMD_DESTROY, 10'd1, '0);
    send(CMD_FLUSH, '0, '0);
    send(CMD_ALLOC, '0, '0);
    send(CMD_CHECK, '0, 16'd1);

    // random phases across capacities, oversize value saturates;
    // every fourth phase runs without bubbles on either side
    for (p = 0; p < 10; p++) begin
      write_capacity(CNT_W'(phase_cap[p]));
      @(negedge clk);
      calm = (p % 4 == 3);
      for (n = 0; n < 180; n++) send_random();
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run including clearing passes
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== generational_slot_allocator.f =====
sv/gsa_pkg.sv
sv/gsa_free_stack.sv
sv/generational_slot_allocator.sv
test/generational_slot_allocator_tb.sv
